FILE: design/mesh_volume_centroid_defines.svh
// ---------------------------------------------------------------------------
// Mesh volume/centroid assertion macros
// Shared concurrent assertion wrappers, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef MESH_VOLUME_CENTROID_DEFINES_SVH
`define MESH_VOLUME_CENTROID_DEFINES_SVH

// same-cycle implication
`define MVC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MVC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mvc_pkg.sv
// ---------------------------------------------------------------------------
// mvc_pkg
// Widths, beat types and finisher states for the mesh volume/centroid block.
// ---------------------------------------------------------------------------
package mvc_pkg;

	localparam int COORD_BITS   = 16;
	localparam int MOMENT_SHIFT = 16;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QA_W         = $clog2(QUEUE_DEPTH);

	// one triangle, coordinates already cut to COORD_BITS (two's complement)
	typedef struct packed {
		logic [COORD_BITS-1:0] ax;
		logic [COORD_BITS-1:0] ay;
		logic [COORD_BITS-1:0] az;
		logic [COORD_BITS-1:0] bx;
		logic [COORD_BITS-1:0] by;
		logic [COORD_BITS-1:0] bz;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] cz;
		logic                  last;
	} tri_t;

	// accumulator snapshot handed to the finisher at end of mesh
	typedef struct packed {
		logic [63:0] vol;
		logic [63:0] mx;
		logic [63:0] my;
		logic [63:0] mz;
		logic        ovf;
	} snap_t;

	typedef enum logic [1:0] {
		FIN_IDLE,
		FIN_VDIV,
		FIN_CDIV,
		FIN_DONE
	} fin_state_t;

endpackage

FILE: design/mvc_front.sv
// ---------------------------------------------------------------------------
// mvc_front
// Input register: takes triangle beats, trims coordinates, tags last.
// ---------------------------------------------------------------------------
module mvc_front import mvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	input  logic signed [15:0] c_x,
	input  logic signed [15:0] c_y,
	input  logic signed [15:0] c_z,
	input  logic               last_triangle,
	output logic               push_valid,
	output tri_t               push_data,
	input  logic               push_ready
);

	logic hold_q;
	tri_t data_q;
	tri_t in_tri;

	always_comb begin
		in_tri.ax   = a_x[COORD_BITS-1:0];
		in_tri.ay   = a_y[COORD_BITS-1:0];
		in_tri.az   = a_z[COORD_BITS-1:0];
		in_tri.bx   = b_x[COORD_BITS-1:0];
		in_tri.by   = b_y[COORD_BITS-1:0];
		in_tri.bz   = b_z[COORD_BITS-1:0];
		in_tri.cx   = c_x[COORD_BITS-1:0];
		in_tri.cy   = c_y[COORD_BITS-1:0];
		in_tri.cz   = c_z[COORD_BITS-1:0];
		in_tri.last = last_triangle;
	end

	assign in_ready   = !hold_q || push_ready;
	assign push_valid = hold_q;
	assign push_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_ready) begin
			hold_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_tri;
		end
	end

endmodule

FILE: design/mvc_queue.sv
// ---------------------------------------------------------------------------
// mvc_queue
// Small triangle FIFO between the front and the arithmetic pipeline.
// ---------------------------------------------------------------------------
module mvc_queue import mvc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  tri_t push_data,
	output logic push_ready,
	output logic pop_valid,
	output tri_t pop_data,
	input  logic pop_ready
);

	tri_t            mem_q [QUEUE_DEPTH];
	logic [QA_W-1:0] wr_q;
	logic [QA_W-1:0] rd_q;
	logic [QA_W:0]   cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = (cnt_q != (QA_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

FILE: design/mvc_back.sv
// ---------------------------------------------------------------------------
// mvc_back
// Four-stage triple-product / moment pipeline with saturating accumulators.
// ---------------------------------------------------------------------------
module mvc_back import mvc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  pop_valid,
	input  tri_t  pop_data,
	output logic  pop_ready,
	output logic  snap_valid,
	output snap_t snap,
	input  logic  snap_ready
);

	`include "mesh_volume_centroid_defines.svh"

	localparam int CW  = COORD_BITS;
	localparam int PW2 = 2*CW;
	localparam int DW  = 2*CW + 1;
	localparam int MW  = 3*CW + 1;
	localparam int PW  = 3*CW + 3;
	localparam int SW  = CW + 2;
	localparam int WW  = (PW > MOMENT_SHIFT) ? (PW - MOMENT_SHIFT) : 1;
	localparam int XW  = WW + SW;
	localparam int EW  = (XW > 64) ? XW : 64;
	localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	// {overflow, saturated sum}
	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		logic [64:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) r = {1'b1, (s[64] ? S64_MIN : S64_MAX)};
		else r = {1'b0, s[63:0]};
		return r;
	endfunction

	logic adv;

	// stage 1: cross-product terms
	logic                  v_s1, last_s1;
	logic signed [CW-1:0]  ax_s1, ay_s1, az_s1;
	logic signed [PW2-1:0] t0_s1, t1_s1, t2_s1, t3_s1, t4_s1, t5_s1;
	logic signed [SW-1:0]  sx_s1, sy_s1, sz_s1;
	// stage 2: a times cross product
	logic                  v_s2, last_s2;
	logic signed [MW-1:0]  m0_s2, m1_s2, m2_s2;
	logic signed [SW-1:0]  sx_s2, sy_s2, sz_s2;
	// stage 3: triple product and weight
	logic                  v_s3, last_s3;
	logic signed [PW-1:0]  p_s3;
	logic signed [WW-1:0]  w_s3;
	logic signed [SW-1:0]  sx_s3, sy_s3, sz_s3;
	// stage 4: moments
	logic                  v_s4, last_s4;
	logic [63:0]           p_s4;
	logic [63:0]           mx_s4, my_s4, mz_s4;
	logic [2:0]            movf_s4;

	logic [63:0] vol_q, mx_q, my_q, mz_q;
	logic        flag_q;

	logic signed [CW-1:0]  iax, iay, iaz, ibx, iby, ibz, icx, icy, icz;
	logic signed [DW-1:0]  d0, d1, d2;
	logic signed [PW-1:0]  p_c;
	logic signed [XW-1:0]  px, py, pz;
	logic signed [EW-1:0]  ex, ey, ez;
	logic [63:0]           mx_c, my_c, mz_c;
	logic [2:0]            movf_c;
	logic [64:0]           nv, nx, ny, nz;

	assign adv       = !(v_s4 && last_s4 && !snap_ready);
	assign pop_ready = adv;

	always_comb begin
		iax = $signed(pop_data.ax); iay = $signed(pop_data.ay); iaz = $signed(pop_data.az);
		ibx = $signed(pop_data.bx); iby = $signed(pop_data.by); ibz = $signed(pop_data.bz);
		icx = $signed(pop_data.cx); icy = $signed(pop_data.cy); icz = $signed(pop_data.cz);
	end

	always_comb begin
		d0  = DW'(t0_s1) - DW'(t1_s1);
		d1  = DW'(t2_s1) - DW'(t3_s1);
		d2  = DW'(t4_s1) - DW'(t5_s1);
		p_c = PW'(m0_s2) + PW'(m1_s2) + PW'(m2_s2);
	end

	always_comb begin
		px = XW'(w_s3) * XW'(sx_s3);
		py = XW'(w_s3) * XW'(sy_s3);
		pz = XW'(w_s3) * XW'(sz_s3);
		ex = EW'(px);
		ey = EW'(py);
		ez = EW'(pz);
		movf_c[0] = (ex[EW-1:63] != {(EW-63){ex[63]}});
		movf_c[1] = (ey[EW-1:63] != {(EW-63){ey[63]}});
		movf_c[2] = (ez[EW-1:63] != {(EW-63){ez[63]}});
		mx_c = movf_c[0] ? (ex[EW-1] ? S64_MIN : S64_MAX) : ex[63:0];
		my_c = movf_c[1] ? (ey[EW-1] ? S64_MIN : S64_MAX) : ey[63:0];
		mz_c = movf_c[2] ? (ez[EW-1] ? S64_MIN : S64_MAX) : ez[63:0];
	end

	always_comb begin
		nv = sat_add(vol_q, p_s4);
		nx = sat_add(mx_q, mx_s4);
		ny = sat_add(my_q, my_s4);
		nz = sat_add(mz_q, mz_s4);
		snap.vol   = nv[63:0];
		snap.mx    = nx[63:0];
		snap.my    = ny[63:0];
		snap.mz    = nz[63:0];
		snap.ovf   = flag_q | nv[64] | nx[64] | ny[64] | nz[64] | (|movf_s4);
		snap_valid = v_s4 && last_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			vol_q  <= '0;
			mx_q   <= '0;
			my_q   <= '0;
			mz_q   <= '0;
			flag_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				if (last_s4) begin
					vol_q  <= '0;
					mx_q   <= '0;
					my_q   <= '0;
					mz_q   <= '0;
					flag_q <= 1'b0;
				end else begin
					vol_q  <= nv[63:0];
					mx_q   <= nx[63:0];
					my_q   <= ny[63:0];
					mz_q   <= nz[63:0];
					flag_q <= snap.ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= pop_data.last;
			ax_s1 <= iax; ay_s1 <= iay; az_s1 <= iaz;
			t0_s1 <= PW2'(iby) * PW2'(icz);
			t1_s1 <= PW2'(ibz) * PW2'(icy);
			t2_s1 <= PW2'(ibz) * PW2'(icx);
			t3_s1 <= PW2'(ibx) * PW2'(icz);
			t4_s1 <= PW2'(ibx) * PW2'(icy);
			t5_s1 <= PW2'(iby) * PW2'(icx);
			sx_s1 <= SW'(iax) + SW'(ibx) + SW'(icx);
			sy_s1 <= SW'(iay) + SW'(iby) + SW'(icy);
			sz_s1 <= SW'(iaz) + SW'(ibz) + SW'(icz);

			last_s2 <= last_s1;
			m0_s2 <= MW'(ax_s1) * MW'(d0);
			m1_s2 <= MW'(ay_s1) * MW'(d1);
			m2_s2 <= MW'(az_s1) * MW'(d2);
			sx_s2 <= sx_s1; sy_s2 <= sy_s1; sz_s2 <= sz_s1;

			last_s3 <= last_s2;
			p_s3  <= p_c;
			w_s3  <= WW'(p_c >>> MOMENT_SHIFT);
			sx_s3 <= sx_s2; sy_s3 <= sy_s2; sz_s3 <= sz_s2;

			last_s4 <= last_s3;
			p_s4    <= 64'(p_s3);
			mx_s4   <= mx_c;
			my_s4   <= my_c;
			mz_s4   <= mz_c;
			movf_s4 <= movf_c;
		end
	end

	`MVC_ASSERT_IMP(a_stall_only_on_last, !adv, v_s4 && last_s4, "stall without end of mesh")
	`MVC_ASSERT_NXT(a_clear_after_last, v_s4 && last_s4 && adv, vol_q == '0 && !flag_q, "not cleared")
	`MVC_ASSERT_NXT(a_hold_on_stall, !adv, v_s4 && last_s4 && $stable(vol_q), "moved in stall")

endmodule

FILE: design/mvc_final.sv
// ---------------------------------------------------------------------------
// mvc_final
// End-of-mesh finisher: volume/6 in four reciprocal digit steps, then three
// serial centroid divides, skipped when the volume is zero.
// ---------------------------------------------------------------------------
module mvc_final import mvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               snap_valid,
	input  snap_t              snap,
	output logic               snap_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] volume,
	output logic signed [15:0] centroid_x,
	output logic signed [15:0] centroid_y,
	output logic signed [15:0] centroid_z,
	output logic               zero_volume,
	output logic               overflowed
);

	`include "mesh_volume_centroid_defines.svh"

	localparam int NW  = 64 + MOMENT_SHIFT;
	localparam int DSW = 64 + 2 + 17;
	localparam int RW  = (NW > DSW) ? NW : DSW;
	localparam logic [5:0] VDIV_LAST = 6'd3;
	localparam logic [5:0] CD_LOAD   = 6'd0;
	localparam logic [5:0] CD_BIG    = 6'd1;
	localparam logic [5:0] CD_WB     = 6'd19;
	localparam logic [1:0] AX_LAST   = 2'd2;
	// ceil(2^19/3): exact divide by three for 18-bit dividends
	localparam logic [17:0] RECIP3   = 18'h2AAAB;

	function automatic logic [63:0] mag64(input logic [63:0] a);
		return a[63] ? (64'd0 - a) : a;
	endfunction

	fin_state_t st_q, st_d;
	snap_t      snap_q;
	logic [5:0] cnt_q;
	logic [1:0] axis_q;
	logic [63:0] vm_q, vq_q;
	logic [1:0]  vr_q;
	logic [RW-1:0] rem_q, dsh_q;
	logic [16:0] cq_q;
	logic        big_q;

	logic [17:0] vt;
	logic [35:0] vprod;
	logic [15:0] vqd;
	logic [17:0] vrw;
	logic [63:0] am;
	logic        rge;
	logic [17:0] qm;
	logic        cneg;
	logic [15:0] cres;
	logic        vol_zero;

	assign vol_zero = (snap_q.vol == '0);

	always_comb begin
		// |vol|/6 = (|vol|>>1)/3, long division by three on 16-bit digits
		vt    = {vr_q, vm_q[63:48]};
		vprod = vt * RECIP3;
		vqd   = vprod[34:19];
		vrw   = vt - ({1'b0, vqd, 1'b0} + {2'b0, vqd});
		case (axis_q)
			2'd0:    am = snap_q.mx;
			2'd1:    am = snap_q.my;
			default: am = snap_q.mz;
		endcase
		rge  = (rem_q >= dsh_q);
		qm   = big_q ? 18'h10000 : {1'b0, cq_q};
		cneg = am[63] ^ snap_q.vol[63];
		if (cneg) cres = (qm > 18'd32768) ? 16'h8000 : 16'(18'd0 - qm);
		else      cres = (qm > 18'd32767) ? 16'h7fff : qm[15:0];
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			FIN_IDLE: if (snap_valid) st_d = FIN_VDIV;
			FIN_VDIV: if (cnt_q == VDIV_LAST) st_d = FIN_CDIV;
			FIN_CDIV: begin
				if (cnt_q == CD_LOAD && vol_zero) st_d = FIN_DONE;
				else if (cnt_q == CD_WB && axis_q == AX_LAST) st_d = FIN_DONE;
			end
			FIN_DONE: if (out_ready) st_d = FIN_IDLE;
			default:  st_d = FIN_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		snap_ready = (st_q == FIN_IDLE);
		out_valid  = (st_q == FIN_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= FIN_IDLE;
			cnt_q  <= '0;
			axis_q <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				FIN_IDLE: begin
					cnt_q  <= '0;
					axis_q <= '0;
				end
				FIN_VDIV: begin
					if (cnt_q == VDIV_LAST) cnt_q <= '0;
					else cnt_q <= cnt_q + 1'b1;
				end
				FIN_CDIV: begin
					if (cnt_q == CD_WB) begin
						cnt_q  <= '0;
						axis_q <= axis_q + 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			FIN_IDLE: begin
				snap_q <= snap;
				vm_q   <= mag64(snap.vol) >> 1;
				vq_q   <= '0;
				vr_q   <= '0;
			end
			FIN_VDIV: begin
				vr_q <= vrw[1:0];
				vq_q <= {vq_q[47:0], vqd};
				vm_q <= {vm_q[47:0], 16'd0};
			end
			FIN_CDIV: begin
				if (cnt_q == CD_LOAD) begin
					rem_q <= RW'(mag64(am)) << MOMENT_SHIFT;
					dsh_q <= RW'(mag64(snap_q.vol)) << 19;
					cq_q  <= '0;
					big_q <= 1'b0;
					if (axis_q == 2'd0) begin
						volume      <= snap_q.vol[63] ? (64'd0 - vq_q) : vq_q;
						zero_volume <= vol_zero;
						overflowed  <= snap_q.ovf;
						centroid_x  <= '0;
						centroid_y  <= '0;
						centroid_z  <= '0;
					end
				end else if (cnt_q == CD_WB) begin
					case (axis_q)
						2'd0:    centroid_x <= cres;
						2'd1:    centroid_y <= cres;
						default: centroid_z <= cres;
					endcase
				end else begin
					if (rge) rem_q <= rem_q - dsh_q;
					dsh_q <= dsh_q >> 1;
					if (cnt_q == CD_BIG) big_q <= rge;
					else cq_q <= {cq_q[15:0], rge};
				end
			end
			default: ;
		endcase
	end

	`MVC_ASSERT_NXT(a_start_div, st_q == FIN_IDLE && snap_valid, st_q == FIN_VDIV, "no start")
	`MVC_ASSERT_IMP(a_axis_range, st_q == FIN_CDIV, axis_q != 2'd3, "axis out of range")
	`MVC_ASSERT_IMP(a_zero_centroid, out_valid && zero_volume, {centroid_x, centroid_y, centroid_z} == '0, "centroid set")

endmodule

FILE: design/mesh_volume_centroid.sv
// ---------------------------------------------------------------------------
// mesh_volume_centroid
// Signed volume and centroid of a closed triangle mesh, fixed point.
// ---------------------------------------------------------------------------
// Usage notes:
//  - Input channel: one triangle per beat (nine signed coordinates plus
//    last_triangle), valid/ready. Accepts one beat per cycle while the
//    four-entry queue has room.
//  - Per triangle: a four-stage multiplier pipeline forms the triple
//    product and the three moments; a saturating 64-bit accumulator stage
//    adds them. One triangle per clock except in an end-of-mesh stall.
//  - Output channel: one result beat per mesh, after the beat flagged last.
//    The last beat passes the front register, the queue and pipeline
//    stages s1 to s4 to the accumulator stage; the finisher then loads the
//    snapshot, runs the divide by six, then the shared restoring centroid
//    divider once per axis (skipped when the volume is zero). It takes no
//    new snapshot until its result has been taken.
//  - The next mesh keeps streaming during the divide; only a second last
//    beat waits at the accumulator stage until the finisher is free again.
//  - Receiver stall: the result is held until out_ready; backpressure then
//    reaches in_ready once the pipeline and queue fill.
//  - Reset clears the accumulators, overflow flag, queue and all valids.
// ---------------------------------------------------------------------------
module mesh_volume_centroid import mvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	input  logic signed [15:0] c_x,
	input  logic signed [15:0] c_y,
	input  logic signed [15:0] c_z,
	input  logic               last_triangle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] volume,
	output logic signed [15:0] centroid_x,
	output logic signed [15:0] centroid_y,
	output logic signed [15:0] centroid_z,
	output logic               zero_volume,
	output logic               overflowed
);

	// front -> queue
	logic  push_valid, push_ready;
	tri_t  push_data;
	// queue -> pipeline
	logic  pop_valid, pop_ready;
	tri_t  pop_data;
	// pipeline -> finisher, accumulator snapshot at end of mesh
	logic  snap_valid, snap_ready;
	snap_t snap;

	mvc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.a_x           (a_x),
		.a_y           (a_y),
		.a_z           (a_z),
		.b_x           (b_x),
		.b_y           (b_y),
		.b_z           (b_z),
		.c_x           (c_x),
		.c_y           (c_y),
		.c_z           (c_z),
		.last_triangle (last_triangle),
		.push_valid    (push_valid),
		.push_data     (push_data),
		.push_ready    (push_ready)
	);

	mvc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	mvc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready)
	);

	// divide stage; its registers are the output beat
	mvc_final u_final (
		.clk         (clk),
		.arst_n      (arst_n),
		.snap_valid  (snap_valid),
		.snap        (snap),
		.snap_ready  (snap_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.volume      (volume),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.centroid_z  (centroid_z),
		.zero_volume (zero_volume),
		.overflowed  (overflowed)
	);

endmodule

FILE: sim/mvc_scoreboard.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mvc_scoreboard
// Watches both channels of mesh_volume_centroid, predicts each mesh result
// from the accepted triangle beats and checks the result beats in order.
// ---------------------------------------------------------------------------
module mvc_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] a_x,
	input  logic signed [15:0] a_y,
	input  logic signed [15:0] a_z,
	input  logic signed [15:0] b_x,
	input  logic signed [15:0] b_y,
	input  logic signed [15:0] b_z,
	input  logic signed [15:0] c_x,
	input  logic signed [15:0] c_y,
	input  logic signed [15:0] c_z,
	input  logic               last_triangle,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [63:0] volume,
	input  logic signed [15:0] centroid_x,
	input  logic signed [15:0] centroid_y,
	input  logic signed [15:0] centroid_z,
	input  logic               zero_volume,
	input  logic               overflowed,
	output int                 fail_count,
	output int                 meshes_pending,
	output int                 meshes_checked,
	output int                 zero_meshes,
	output int                 clamped_meshes
);

	localparam longint S64_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

	typedef struct {
		longint          vol;
		logic signed [15:0] cx, cy, cz;
		logic            zv;
		logic            ovf;
	} mesh_result_t;

	mesh_result_t mesh_q[$];

	longint vol_acc, mom_x, mom_y, mom_z;
	bit     sat_seen;

	function automatic longint add_sat(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(S64_MAX)) begin
			sat_seen = 1;
			return S64_MAX;
		end
		if (s < 65'(S64_MIN)) begin
			sat_seen = 1;
			return S64_MIN;
		end
		return longint'(s);
	endfunction

	function automatic longint mul_sat(longint a, longint b);
		logic signed [127:0] wa, wb, pr;
		wa = a;
		wb = b;
		pr = wa * wb;
		if (pr > 128'sd0 + S64_MAX) begin
			sat_seen = 1;
			return S64_MAX;
		end
		if (pr < 128'(S64_MIN)) begin
			sat_seen = 1;
			return S64_MIN;
		end
		return longint'(pr);
	endfunction

	// |acc| * 2^16 / (4 |total|), truncated, then clamped to 16 bits signed
	function automatic logic signed [15:0] centroid_of(longint acc, longint tot);
		logic signed [127:0] sa, st;
		logic [127:0]        q;
		bit                  neg;
		sa  = acc;
		st  = tot;
		neg = (acc < 0) != (tot < 0);
		if (sa < 0) sa = -sa;
		if (st < 0) st = -st;
		q = (128'(sa) << 16) / (128'(st) << 2);
		if (neg) return (q > 32768) ? -16'sd32768 : 16'(-$signed(q[16:0]));
		return (q > 32767) ? 16'sd32767 : 16'(q);
	endfunction

	// adds one triangle; on the last beat returns the mesh result and clears
	function automatic bit add_triangle(output mesh_result_t r);
		longint ax, ay, az, bx, by, bz, cx, cy, cz, p, w;
		ax = a_x; ay = a_y; az = a_z;
		bx = b_x; by = b_y; bz = b_z;
		cx = c_x; cy = c_y; cz = c_z;
		p = ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
		w = p >>> 16;
		vol_acc = add_sat(vol_acc, p);
		mom_x   = add_sat(mom_x, mul_sat(w, ax + bx + cx));
		mom_y   = add_sat(mom_y, mul_sat(w, ay + by + cy));
		mom_z   = add_sat(mom_z, mul_sat(w, az + bz + cz));
		if (!last_triangle)
			return 0;
		r.vol = vol_acc / 6;
		r.zv  = (vol_acc == 0);
		r.ovf = sat_seen;
		if (r.zv) begin
			r.cx = 0; r.cy = 0; r.cz = 0;
		end else begin
			r.cx = centroid_of(mom_x, vol_acc);
			r.cy = centroid_of(mom_y, vol_acc);
			r.cz = centroid_of(mom_z, vol_acc);
		end
		vol_acc = 0; mom_x = 0; mom_y = 0; mom_z = 0; sat_seen = 0;
		return 1;
	endfunction

	assign meshes_pending = mesh_q.size();

	always @(posedge clk or negedge arst_n) begin
		mesh_result_t r, e;
		int           errs;
		if (!arst_n) begin
			vol_acc = 0; mom_x = 0; mom_y = 0; mom_z = 0; sat_seen = 0;
			mesh_q.delete();
			fail_count     <= 0;
			meshes_checked <= 0;
			zero_meshes    <= 0;
			clamped_meshes <= 0;
		end else begin
			errs = 0;
			if (in_valid && in_ready && add_triangle(r))
				mesh_q.push_back(r);
			if (out_valid && out_ready) begin
				if (mesh_q.size() == 0) begin
					$error("result beat with no mesh outstanding");
					errs++;
				end else begin
					e = mesh_q.pop_front();
					meshes_checked <= meshes_checked + 1;
					if (e.zv) zero_meshes <= zero_meshes + 1;
					if (!e.zv && (e.cx == 32767 || e.cx == -32768 || e.cy == 32767
						|| e.cy == -32768 || e.cz == 32767 || e.cz == -32768))
						clamped_meshes <= clamped_meshes + 1;
					if (volume !== e.vol) begin
						$error("volume: expected %0d, got %0d", e.vol, volume);
						errs++;
					end
					if (centroid_x !== e.cx) begin
						$error("centroid_x: expected %0d, got %0d", e.cx, centroid_x);
						errs++;
					end
					if (centroid_y !== e.cy) begin
						$error("centroid_y: expected %0d, got %0d", e.cy, centroid_y);
						errs++;
					end
					if (centroid_z !== e.cz) begin
						$error("centroid_z: expected %0d, got %0d", e.cz, centroid_z);
						errs++;
					end
					if (zero_volume !== e.zv) begin
						$error("zero_volume: expected %0b, got %0b", e.zv, zero_volume);
						errs++;
					end
					if (overflowed !== e.ovf) begin
						$error("overflowed: expected %0b, got %0b", e.ovf, overflowed);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

FILE: sim/tb_mesh_volume_centroid.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mesh_volume_centroid
// Streams triangle meshes into mesh_volume_centroid with random gaps and
// output stalls; the scoreboard beside the block checks every result beat.
// ---------------------------------------------------------------------------
module tb_mesh_volume_centroid;
	import mvc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic               last_triangle;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] volume;
	logic signed [15:0] centroid_x, centroid_y, centroid_z;
	logic               zero_volume, overflowed;

	int fail_count, meshes_pending, meshes_checked, zero_meshes, clamped_meshes;
	int tri_sent;
	int quiet_cycles;
	bit no_idle;      // set for the stretch with no gaps on either side
	bit stim_done;

	mesh_volume_centroid dut (.*);

	mvc_scoreboard scb (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver: stalls about a quarter of the time, never during no_idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 26);
		end
	end

	// watchdog: counts cycles in which no beat moves on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d meshes outstanding", meshes_pending);
			$display("status: fail");
			$finish;
		end
	end

	// one triangle beat; each cycle before it is idle with a chance of about
	// a quarter. valid is only dropped when a gap is taken, so it never falls
	// and rises within one time step
	task automatic send_tri(input logic signed [15:0] v[9], input logic lst);
		if (!no_idle && $urandom_range(99) < 26) begin
			in_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < 26);
		end
		in_valid <= 1;
		a_x <= v[0]; a_y <= v[1]; a_z <= v[2];
		b_x <= v[3]; b_y <= v[4]; b_z <= v[5];
		c_x <= v[6]; c_y <= v[7]; c_z <= v[8];
		last_triangle <= lst;
		do @(posedge clk); while (!in_ready);
		tri_sent++;
	endtask

	task automatic send_fill(input logic signed [15:0] fill, input logic lst);
		logic signed [15:0] v[9];
		foreach (v[i]) v[i] = fill;
		send_tri(v, lst);
	endtask

	// random mesh: mostly small coordinates (small volumes, clamped
	// centroids), some full-range ones to toggle every bit
	task automatic send_mesh(input int n_tri);
		logic signed [15:0] v[9];
		int                 span;
		span = $urandom_range(3);
		for (int t = 0; t < n_tri; t++) begin
			foreach (v[i]) begin
				case (span)
					0: v[i] = 16'($urandom);
					1: v[i] = 16'(int'($urandom_range(0, 4)) - 2);
					2: v[i] = 16'(int'($urandom_range(0, 400)) - 200);
					default: v[i] = ($urandom_range(3) == 0) ? 16'($urandom)
						: 16'(int'($urandom_range(0, 8000)) - 4000);
				endcase
			end
			send_tri(v, t == n_tri - 1);
		end
	endtask

	initial begin
		logic signed [15:0] v[9];
		arst_n        = 0;
		in_valid      = 0;
		last_triangle = 0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		no_idle   = 0;
		stim_done = 0;
		tri_sent  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: degenerate and extreme triangles
		send_fill(16'sd0, 1);         // zero volume
		send_fill(16'sd32767, 1);     // all vertices equal: zero volume
		send_fill(-16'sd32768, 1);
		v = '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd0,
		      16'sd0, 16'sd0, 16'sd32767};
		send_tri(v, 1);               // largest positive triple product
		v = '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0,
		      16'sd0, 16'sd0, -16'sd32768};
		send_tri(v, 1);               // largest negative triple product
		v = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1};
		send_tri(v, 1);               // p = -1: floor shift gives -1, centroid stays in range
		v = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
		send_tri(v, 0);               // p = +1 then its mirror: total zero
		v = '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, -16'sd1};
		send_tri(v, 1);
		// unit tetrahedron scaled, four faces, outward winding
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1600, 16'sd0, 16'sd1600, 16'sd0, 16'sd0};
		send_tri(v, 0);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd1600, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1600};
		send_tri(v, 0);
		v = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1600, 16'sd0, 16'sd1600, 16'sd0};
		send_tri(v, 0);
		v = '{16'sd1600, 16'sd0, 16'sd0, 16'sd0, 16'sd1600, 16'sd0, 16'sd0, 16'sd0, 16'sd1600};
		send_tri(v, 1);

		// hold off until every mesh result has come back
		in_valid <= 0;
		while (meshes_pending != 0) @(posedge clk);

		// random meshes; the middle stretch runs with no gaps on either side
		while (tri_sent < 940) begin
			no_idle = (tri_sent > 400 && tri_sent < 560);
			send_mesh($urandom_range(1, 8));
		end
		no_idle = 0;
		in_valid <= 0;
		stim_done = 1;

		while (meshes_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d triangle beats sent, %0d mesh results checked", tri_sent,
			meshes_checked);
		$display("%0d meshes of zero volume, %0d with a clamped centroid", zero_meshes,
			clamped_meshes);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
